>>> rtl/pmr_pkg.sv
// Shared constants and types for the Park-Miller generator.
// Used by pmr_div and park_miller_random_generator; no dependencies.
package pmr_pkg;

  localparam int unsigned STATE_W = 31;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned CNT_W   = $clog2(STATE_W);
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned PROD_W  = STATE_W + MULT_W;

  localparam logic [STATE_W-1:0] PM_MODULUS = 31'h7fff_ffff;
  localparam logic [MULT_W-1:0]  PM_MULT    = 15'd16807;

  localparam logic [1:0] OP_RAW     = 2'd0;
  localparam logic [1:0] OP_UNIFORM = 2'd1;
  localparam logic [1:0] OP_ONE_IN  = 2'd2;
  localparam logic [1:0] OP_SKEWED  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_DIV,
    ST_OUT
  } fsm_t;

  function automatic logic [STATE_W-1:0] clean_seed(input logic [DIV_W-1:0] s);
    logic [STATE_W-1:0] v;
    v = s[STATE_W-1:0];
    if (v == '0 || v == PM_MODULUS) begin
      v = STATE_W'(1);
    end
    return v;
  endfunction

endpackage

>>> rtl/pmr_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on pmr_pkg for widths.
module pmr_div
  import pmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [STATE_W-1:0] dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   remainder
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [STATE_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0]   dsr_r, dsr_nxt;
  logic [DIV_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[STATE_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STATE_W - 1);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      dvd_nxt = {dvd_r[STATE_W-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

>>> rtl/park_miller_random_generator.sv
// Park-Miller minimal standard generator (x16807 mod 2^31-1) with request decode.
// Depends on pmr_pkg and pmr_div.
//
//   channel  | ports                                     | direction
//   ---------+-------------------------------------------+----------
//   request  | in_valid/in_ready, operation, bound, max_log | in
//   result   | out_valid/out_ready, value                | out
//   seed     | cfg_valid/cfg_ready, seed_value           | in
//
// Raw draw: multiply, fold, then output step. Uniform and one-in: multiply, fold,
// then the 31-step shared remainder unit, then output; a zero bound skips to output.
// Skewed: two state advances around one remainder pass, then output.
// One item is in work at a time; in_ready is low until the result register is
// loaded, and a stalled result holds the sequencer in its output step.
// Synchronous active-low reset loads state 1. Seed writes are taken while idle.
module park_miller_random_generator
  import pmr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_bound,
  input  logic [4:0]         in_max_log,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STATE_W-1:0] out_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DIV_W-1:0]   cfg_seed_value
);

  fsm_t               fsm_r, fsm_nxt;
  logic [STATE_W-1:0] gen_r, gen_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [DIV_W-1:0]   bound_r, bound_nxt;
  logic [4:0]         max_log_r, max_log_nxt;
  logic [4:0]         shift_r, shift_nxt;
  logic               second_r, second_nxt;
  logic [STATE_W-1:0] res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STATE_W-1:0] out_value_r, out_value_nxt;

  logic               in_acc, out_free, zero_bound;
  logic [DIV_W-1:0]   folded;
  logic [STATE_W-1:0] fold_state;
  logic [DIV_W-1:0]   skew_mask;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_divisor, div_rem;

  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign zero_bound = (in_bound == '0) &&
                      (in_operation == OP_UNIFORM || in_operation == OP_ONE_IN);

  assign folded     = DIV_W'(prod_r[PROD_W-1:STATE_W]) + DIV_W'(prod_r[STATE_W-1:0]);
  assign fold_state = (folded > DIV_W'(PM_MODULUS)) ?
                      STATE_W'(folded - DIV_W'(PM_MODULUS)) : folded[STATE_W-1:0];
  assign skew_mask  = (DIV_W'(1) << shift_r) - DIV_W'(1);

  pmr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (fold_state),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    fsm_nxt = fsm_r;
    unique case (fsm_r)
      ST_IDLE: begin
        if (in_acc) begin
          fsm_nxt = zero_bound ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL:  fsm_nxt = ST_FOLD;
      ST_FOLD: begin
        if (op_r == OP_RAW || (op_r == OP_SKEWED && second_r)) begin
          fsm_nxt = ST_OUT;
        end else begin
          fsm_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          fsm_nxt = (op_r == OP_SKEWED) ? ST_MUL : ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          fsm_nxt = ST_IDLE;
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    gen_nxt       = gen_r;
    prod_nxt      = prod_r;
    op_nxt        = op_r;
    bound_nxt     = bound_r;
    max_log_nxt   = max_log_r;
    shift_nxt     = shift_r;
    second_nxt    = second_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    div_start     = 1'b0;
    div_divisor   = (op_r == OP_SKEWED) ? DIV_W'(max_log_r) + DIV_W'(1) : bound_r;
    in_ready      = (fsm_r == ST_IDLE);
    cfg_ready     = (fsm_r == ST_IDLE);

    unique case (fsm_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          gen_nxt = clean_seed(cfg_seed_value);
        end
        if (in_acc) begin
          op_nxt      = in_operation;
          bound_nxt   = in_bound;
          max_log_nxt = in_max_log;
          second_nxt  = 1'b0;
          res_nxt     = (in_operation == OP_ONE_IN) ? STATE_W'(1) : '0;
        end
      end
      ST_MUL: begin
        prod_nxt = PROD_W'(gen_r) * PROD_W'(PM_MULT);
      end
      ST_FOLD: begin
        gen_nxt = fold_state;
        if (op_r == OP_RAW) begin
          res_nxt = fold_state;
        end else if (op_r == OP_SKEWED && second_r) begin
          res_nxt = fold_state & skew_mask[STATE_W-1:0];
        end
      end
      ST_DIV: begin
        div_start = 1'b0;
        if (div_done) begin
          case (op_r)
            OP_ONE_IN: res_nxt = (div_rem == '0) ? STATE_W'(1) : '0;
            OP_SKEWED: begin
              shift_nxt  = div_rem[4:0];
              second_nxt = 1'b1;
            end
            default:   res_nxt = div_rem[STATE_W-1:0];
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
        end
      end
      default: ;
    endcase

    if (fsm_r == ST_FOLD && fsm_nxt == ST_DIV) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      gen_r       <= STATE_W'(1);
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      op_r        <= OP_RAW;
    end else begin
      fsm_r       <= fsm_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
      op_r        <= op_nxt;
    end
    prod_r      <= prod_nxt;
    bound_r     <= bound_nxt;
    max_log_r   <= max_log_nxt;
    shift_r     <= shift_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  ap_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != '0)
    else $error("generator state reached zero");

  ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while an item is in work");

  ap_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> fsm_r == ST_DIV)
    else $error("remainder finished outside the divide step");

  ap_one_in_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == ST_OUT && out_free && op_r == OP_ONE_IN) |=>
      out_value_r[STATE_W-1:1] == '0)
    else $error("one-in result is not a flag");

endmodule
